### src/scfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame receiver package
// Shared constants, phase codes, result codes and the per-port context type.
// ----------------------------------------------------------------------------
package scfr_pkg;

    localparam int NUM_PORTS = 4;
    localparam int BUF_DEPTH = 64;

    localparam int CTX_AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int BUF_AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int PAY_DEPTH = NUM_PORTS * BUF_DEPTH;
    localparam int PAY_AW = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_DOLLAR = 3'd1;
    localparam logic [2:0] PH_M      = 3'd2;
    localparam logic [2:0] PH_ARROW  = 3'd3;
    localparam logic [2:0] PH_LEN    = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_ARROW  = 8'h3C;

    localparam logic [1:0] EV_PASS = 2'd0;
    localparam logic [1:0] EV_GOOD = 2'd1;
    localparam logic [1:0] EV_BAD  = 2'd2;

    localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd64;

    typedef struct packed {
        logic [2:0] phase;
        logic [6:0] exp_len;
        logic [6:0] rcvd;
        logic [7:0] csum;
        logic [7:0] cmd;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

    localparam ctx_t CTX_RESET = '{
        phase:   PH_HUNT,
        exp_len: 7'd0,
        rcvd:    7'd0,
        csum:    8'd0,
        cmd:     8'd0
    };

    typedef struct packed {
        logic              en;
        logic [CTX_AW-1:0] addr;
    } ctx_rd_t;

    typedef struct packed {
        logic              en;
        logic [CTX_AW-1:0] addr;
        ctx_t              data;
    } ctx_wr_t;

endpackage

### src/scfr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module scfr_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/scfr_ctx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Per-port parser context store
// A small RAM holding each port's parser context, with one valid bit per port
// so that a port not yet written reads as the reset context.
// ----------------------------------------------------------------------------
module scfr_ctx
    import scfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ctx_rd_t rd,
    output ctx_t    rd_data,
    input  ctx_wr_t wr
);

    logic [NUM_PORTS-1:0] vld_reg;
    logic                 rvld_reg;
    logic [CTX_W-1:0]     ram_q;

    scfr_ram #(
        .WIDTH (CTX_W),
        .DEPTH (NUM_PORTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rvld_reg <= vld_reg[rd.addr];
            end
        end
    end

    assign rd_data = rvld_reg ? ctx_t'(ram_q) : CTX_RESET;

endmodule

### src/serial_command_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame receiver
// Per-port parser for "$M<" command frames. Each port's context lives in a
// small RAM and the payload bytes in a shared payload RAM.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid / in_stall  port, rx_byte
//  output    out_valid/ out_stall event_res, out_port, frame_command, frame_length,
//                                 data_byte, byte_index, has_data, last
//  config    cfg_valid/ cfg_ready max_payload
//
// For each input byte the port's context is read from RAM as the byte is
// accepted, then updated and written back in the execution state. A good frame
// then drains its payload from the payload RAM at one byte per cycle while the
// output is not stalled, and no new input byte is taken until the drain ends.
// Reset returns every port to hunting at once through per-port valid bits. An
// output stall holds the parser wherever it has a result to deliver.
// ----------------------------------------------------------------------------
module serial_command_frame_receiver
    import scfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] port,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_res,
    output logic [1:0] out_port,
    output logic [7:0] frame_command,
    output logic [6:0] frame_length,
    output logic [7:0] data_byte,
    output logic [5:0] byte_index,
    output logic       has_data,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] max_payload
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         port_reg;
    logic [7:0]         byte_reg;
    logic [BUF_AW-1:0]  idx_reg, idx_next;
    logic [6:0]         len_reg, len_next;
    logic [7:0]         cmd_reg, cmd_next;
    logic [6:0]         max_payload_reg;

    logic               out_valid_reg;
    logic [1:0]         event_reg;
    logic [1:0]         out_port_reg;
    logic [7:0]         command_reg;
    logic [6:0]         length_reg;
    logic [7:0]         data_reg;
    logic [5:0]         index_reg;
    logic               has_data_reg;
    logic               last_reg;

    ctx_rd_t            ctx_rd;
    ctx_wr_t            ctx_wr;
    ctx_t               ctx_q;
    ctx_t               ctx_new;

    logic               in_accept;
    logic               can_load;
    logic               port_ok;
    logic [6:0]         limit;
    logic               res_need;
    logic [1:0]         res_event;
    logic [7:0]         res_cmd;
    logic [6:0]         res_len;
    logic [7:0]         res_data;
    logic               res_has;
    logic               go_drain;
    logic               exec_go;
    logic               pay_wr;
    logic               drain_last;
    logic               out_load;

    logic               pay_we;
    logic [PAY_AW-1:0]  pay_waddr;
    logic               pay_re;
    logic [PAY_AW-1:0]  pay_raddr;
    logic [7:0]         pay_q;
    logic [PAY_AW-1:0]  pay_base;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign can_load  = !out_valid_reg || !out_stall;
    assign port_ok   = (4'(port_reg) < 4'(NUM_PORTS));
    assign limit     = (max_payload_reg < 7'(BUF_DEPTH)) ? max_payload_reg : 7'(BUF_DEPTH);
    assign pay_base  = PAY_AW'(port_reg) * PAY_AW'(BUF_DEPTH);

    scfr_ctx u_ctx (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (ctx_rd),
        .rd_data (ctx_q),
        .wr      (ctx_wr)
    );

    scfr_ram #(
        .WIDTH (8),
        .DEPTH (PAY_DEPTH)
    ) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (byte_reg),
        .re    (pay_re),
        .raddr (pay_raddr),
        .rdata (pay_q)
    );

    assign ctx_rd.en   = in_accept;
    assign ctx_rd.addr = CTX_AW'(port);

    always_comb
    begin
        ctx_new   = ctx_q;
        res_need  = 1'b0;
        res_event = EV_PASS;
        res_cmd   = 8'd0;
        res_len   = 7'd0;
        res_data  = 8'd0;
        res_has   = 1'b0;
        go_drain  = 1'b0;
        pay_wr    = 1'b0;
        unique case (ctx_q.phase)
            PH_DOLLAR:
            begin
                ctx_new.phase = (byte_reg == CH_M) ? PH_M : PH_HUNT;
            end
            PH_M:
            begin
                ctx_new.phase = (byte_reg == CH_ARROW) ? PH_ARROW : PH_HUNT;
            end
            PH_ARROW:
            begin
                if (byte_reg > {1'b0, limit})
                begin
                    ctx_new.phase = PH_HUNT;
                end
                else
                begin
                    ctx_new.exp_len = byte_reg[6:0];
                    ctx_new.rcvd    = 7'd0;
                    ctx_new.csum    = byte_reg;
                    ctx_new.phase   = PH_LEN;
                end
            end
            PH_LEN:
            begin
                ctx_new.cmd   = byte_reg;
                ctx_new.csum  = ctx_q.csum ^ byte_reg;
                ctx_new.phase = PH_DATA;
            end
            PH_DATA:
            begin
                if ((ctx_q.rcvd < ctx_q.exp_len) && (ctx_q.rcvd < 7'(BUF_DEPTH)))
                begin
                    ctx_new.csum = ctx_q.csum ^ byte_reg;
                    ctx_new.rcvd = ctx_q.rcvd + 7'd1;
                    pay_wr       = 1'b1;
                end
                else
                begin
                    ctx_new.phase = PH_HUNT;
                    res_cmd       = ctx_q.cmd;
                    if (ctx_q.csum != byte_reg)
                    begin
                        res_need  = 1'b1;
                        res_event = EV_BAD;
                        res_len   = ctx_q.exp_len;
                    end
                    else if (ctx_q.exp_len == 7'd0)
                    begin
                        res_need  = 1'b1;
                        res_event = EV_GOOD;
                    end
                    else
                    begin
                        go_drain = 1'b1;
                    end
                end
            end
            default:
            begin
                ctx_new.phase = (byte_reg == CH_DOLLAR) ? PH_DOLLAR : PH_HUNT;
                if (byte_reg != CH_DOLLAR)
                begin
                    res_need  = 1'b1;
                    res_event = EV_PASS;
                    res_data  = byte_reg;
                    res_has   = 1'b1;
                end
            end
        endcase
    end

    assign exec_go     = !res_need || can_load;
    assign ctx_wr.en   = (state_reg == S_EXEC) && port_ok && exec_go;
    assign ctx_wr.addr = CTX_AW'(port_reg);
    assign ctx_wr.data = ctx_new;

    assign pay_we    = (state_reg == S_EXEC) && port_ok && pay_wr;
    assign pay_waddr = pay_base + PAY_AW'(ctx_q.rcvd);

    assign drain_last = (7'(idx_reg) + 7'd1 == len_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        pay_re     = 1'b0;
        pay_raddr  = pay_base;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!port_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (go_drain)
                begin
                    pay_re     = 1'b1;
                    idx_next   = '0;
                    len_next   = (ctx_q.exp_len > 7'(BUF_DEPTH)) ? 7'(BUF_DEPTH) : ctx_q.exp_len;
                    cmd_next   = ctx_q.cmd;
                    state_next = S_DRAIN;
                end
                else if (exec_go)
                begin
                    out_load   = res_need;
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    if (drain_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pay_re    = 1'b1;
                        pay_raddr = pay_base + PAY_AW'(idx_reg + 1'b1);
                        idx_next  = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_payload_reg <= MAX_PAYLOAD_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                max_payload_reg <= max_payload;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            port_reg <= port;
            byte_reg <= rx_byte;
        end
        idx_reg <= idx_next;
        len_reg <= len_next;
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            out_port_reg <= port_reg;
            if (state_reg == S_DRAIN)
            begin
                event_reg    <= EV_GOOD;
                command_reg  <= cmd_reg;
                length_reg   <= len_reg;
                data_reg     <= pay_q;
                index_reg    <= 6'(idx_reg);
                has_data_reg <= 1'b1;
                last_reg     <= drain_last;
            end
            else
            begin
                event_reg    <= res_event;
                command_reg  <= res_cmd;
                length_reg   <= res_len;
                data_reg     <= res_data;
                index_reg    <= 6'd0;
                has_data_reg <= res_has;
                last_reg     <= 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = event_reg;
    assign out_port      = out_port_reg;
    assign frame_command = command_reg;
    assign frame_length  = length_reg;
    assign data_byte     = data_reg;
    assign byte_index    = index_reg;
    assign has_data      = has_data_reg;
    assign last          = last_reg;

`ifndef ASSERT_OFF
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_EXEC)
        else $error("An accepted transaction did not move the parser to execution.");

    a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> 7'(idx_reg) < len_reg)
        else $error("Drain index ran past the frame length.");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) && out_load && drain_last |=> state_reg == S_IDLE)
        else $error("Drain did not finish after its last byte.");

    a_ctx_wr: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_wr.en |-> state_reg == S_EXEC)
        else $error("Context written outside execution.");

    a_pay_wr: assert property (@(posedge clk) disable iff (!rst_n)
        pay_we |-> (ctx_q.rcvd < 7'(BUF_DEPTH)) && !out_load)
        else $error("Payload write beyond the port buffer or alongside a result.");
`endif

endmodule

### tb/scfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame receiver checker
// Watches the input, output and configuration channels of the receiver. It
// keeps its own per-port frame parser, builds the results due for every
// accepted byte and compares each delivered result against the oldest one.
// ----------------------------------------------------------------------------
module scfr_frame_checker
    import scfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] port,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] event_res,
    input  logic [1:0] out_port,
    input  logic [7:0] frame_command,
    input  logic [6:0] frame_length,
    input  logic [7:0] data_byte,
    input  logic [5:0] byte_index,
    input  logic       has_data,
    input  logic       last,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [6:0] max_payload,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [1:0] ev;
        logic [1:0] prt;
        logic [7:0] cmd;
        logic [6:0] len;
        logic [7:0] data;
        logic [5:0] idx;
        logic       has;
        logic       fin;
    } frame_output_t;

    logic [6:0]    max_len_cfg;
    logic [2:0]    parse_ph    [NUM_PORTS];
    logic [6:0]    want_len    [NUM_PORTS];
    logic [6:0]    got_len     [NUM_PORTS];
    logic [7:0]    xor_sum     [NUM_PORTS];
    logic [7:0]    cmd_byte    [NUM_PORTS];
    logic [7:0]    payload_mem [NUM_PORTS][BUF_DEPTH];
    frame_output_t due_outputs [$];
    int            error_total = 0;

    function automatic frame_output_t make_output(
        input logic [1:0] ev,
        input logic [1:0] prt,
        input logic [7:0] cmd,
        input logic [6:0] len,
        input logic [7:0] data,
        input logic [5:0] idx,
        input logic       has,
        input logic       fin
    );
        frame_output_t r;
        r.ev   = ev;
        r.prt  = prt;
        r.cmd  = cmd;
        r.len  = len;
        r.data = data;
        r.idx  = idx;
        r.has  = has;
        r.fin  = fin;
        return r;
    endfunction

    task automatic parse_rx_byte(input logic [1:0] p, input logic [7:0] b);
        logic [6:0] lim;
        int         i;
        lim = (max_len_cfg < BUF_DEPTH) ? max_len_cfg : 7'(BUF_DEPTH);
        case (parse_ph[p])
            PH_DOLLAR:
                parse_ph[p] = (b == CH_M) ? PH_M : PH_HUNT;
            PH_M:
                parse_ph[p] = (b == CH_ARROW) ? PH_ARROW : PH_HUNT;
            PH_ARROW:
            begin
                if (b > {1'b0, lim})
                begin
                    parse_ph[p] = PH_HUNT;
                end
                else
                begin
                    want_len[p] = b[6:0];
                    got_len[p]  = 7'd0;
                    xor_sum[p]  = b;
                    parse_ph[p] = PH_LEN;
                end
            end
            PH_LEN:
            begin
                cmd_byte[p] = b;
                xor_sum[p]  = xor_sum[p] ^ b;
                parse_ph[p] = PH_DATA;
            end
            PH_DATA:
            begin
                if (got_len[p] < want_len[p] && got_len[p] < BUF_DEPTH)
                begin
                    xor_sum[p] = xor_sum[p] ^ b;
                    payload_mem[p][got_len[p][5:0]] = b;
                    got_len[p] = got_len[p] + 7'd1;
                end
                else
                begin
                    parse_ph[p] = PH_HUNT;
                    if (xor_sum[p] != b)
                    begin
                        due_outputs.push_back(make_output(EV_BAD, p, cmd_byte[p],
                            want_len[p], 8'd0, 6'd0, 1'b0, 1'b1));
                    end
                    else if (want_len[p] == 7'd0)
                    begin
                        due_outputs.push_back(make_output(EV_GOOD, p, cmd_byte[p],
                            7'd0, 8'd0, 6'd0, 1'b0, 1'b1));
                    end
                    else
                    begin
                        for (i = 0; i < int'(want_len[p]); i++)
                        begin
                            due_outputs.push_back(make_output(EV_GOOD, p, cmd_byte[p],
                                want_len[p], payload_mem[p][i], 6'(i), 1'b1,
                                i == int'(want_len[p]) - 1));
                        end
                    end
                end
            end
            default:
            begin
                if (b == CH_DOLLAR)
                begin
                    parse_ph[p] = PH_DOLLAR;
                end
                else
                begin
                    parse_ph[p] = PH_HUNT;
                    due_outputs.push_back(make_output(EV_PASS, p, 8'd0, 7'd0, b,
                        6'd0, 1'b1, 1'b1));
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            error_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_output_t want;
        if (!rst_n)
        begin
            max_len_cfg = MAX_PAYLOAD_RESET;
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                parse_ph[i] = PH_HUNT;
                want_len[i] = 7'd0;
                got_len[i]  = 7'd0;
                xor_sum[i]  = 8'd0;
                cmd_byte[i] = 8'd0;
            end
            due_outputs.delete();
            fail_count <= error_total;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_outputs.size() == 0)
                begin
                    error_total++;
                    $display("%0t: unexpected result, expected none, actual port %0d event %0d",
                             $time, out_port, event_res);
                end
                else
                begin
                    want = due_outputs.pop_front();
                    check_field("event_res", want.ev, event_res);
                    check_field("out_port", want.prt, out_port);
                    check_field("frame_command", want.cmd, frame_command);
                    check_field("frame_length", want.len, frame_length);
                    check_field("data_byte", want.data, data_byte);
                    check_field("byte_index", want.idx, byte_index);
                    check_field("has_data", want.has, has_data);
                    check_field("last", want.fin, last);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                max_len_cfg = max_payload;
            end
            if (in_valid && !in_stall)
            begin
                parse_rx_byte(port, rx_byte);
            end
            fail_count <= error_total;
            pending    <= due_outputs.size();
        end
    end

endmodule

### tb/tb_serial_command_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command frame receiver testbench
// Drives a short directed byte stream and then interleaved random frames,
// broken headers and noise on all ports under several payload limits, with
// random idling on both channels and one long output hold-off. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_serial_command_frame_receiver;
    import scfr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int SEQ_MAX     = 72;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [1:0] port        = 2'd0;
    logic [7:0] rx_byte     = 8'd0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [1:0] event_res;
    logic [1:0] out_port;
    logic [7:0] frame_command;
    logic [6:0] frame_length;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       has_data;
    logic       last;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [6:0] max_payload = MAX_PAYLOAD_RESET;

    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    int         hold_left   = 0;
    logic       hold_req    = 1'b0;
    logic       hold_done   = 1'b0;
    logic       quiet       = 1'b0;
    logic [6:0] cur_max     = MAX_PAYLOAD_RESET;
    logic [7:0] seq_buf [NUM_PORTS][SEQ_MAX];
    int         seq_len [NUM_PORTS];
    int         seq_pos [NUM_PORTS];

    serial_command_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .port          (port),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .out_port      (out_port),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .has_data      (has_data),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .max_payload   (max_payload)
    );

    scfr_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .port          (port),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .out_port      (out_port),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .has_data      (has_data),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .max_payload   (max_payload),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_serial_command_frame_receiver: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 8);
        end
    end

    task automatic push_rx_byte(input logic [1:0] p, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        port     <= p;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic append_byte(input int p, input logic [7:0] b);
        seq_buf[p][seq_len[p]] = b;
        seq_len[p]++;
    endtask

    task automatic queue_sequence(input int p);
        int         kind;
        int         len;
        int         lim;
        logic [7:0] csum;
        logic [7:0] cmd;
        logic [7:0] b;
        lim = (cur_max < BUF_DEPTH) ? int'(cur_max) : BUF_DEPTH;
        seq_len[p] = 0;
        seq_pos[p] = 0;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            append_byte(p, 8'($urandom_range(0, 255)));
        end
        else if (kind < 27)
        begin
            append_byte(p, CH_DOLLAR);
            case ($urandom_range(0, 2))
                0:
                begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_M);
                    append_byte(p, b);
                end
                1:
                begin
                    append_byte(p, CH_M);
                    do b = 8'($urandom_range(0, 255)); while (b == CH_ARROW);
                    append_byte(p, b);
                end
                default:
                begin
                    append_byte(p, CH_M);
                    append_byte(p, CH_ARROW);
                    append_byte(p, 8'($urandom_range(lim + 1, 255)));
                end
            endcase
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                len = lim;
            end
            else
            begin
                len = $urandom_range(0, (lim < 6) ? lim : 6);
            end
            cmd  = 8'($urandom_range(0, 255));
            csum = 8'(len) ^ cmd;
            append_byte(p, CH_DOLLAR);
            append_byte(p, CH_M);
            append_byte(p, CH_ARROW);
            append_byte(p, 8'(len));
            append_byte(p, cmd);
            for (int i = 0; i < len; i++)
            begin
                b    = 8'($urandom_range(0, 255));
                csum = csum ^ b;
                append_byte(p, b);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                csum = csum ^ 8'($urandom_range(1, 255));
            end
            append_byte(p, csum);
        end
    endtask

    task automatic run_phase(input int count);
        int p;
        for (int n = 0; n < count; n++)
        begin
            p = $urandom_range(0, NUM_PORTS - 1);
            if (seq_pos[p] >= seq_len[p])
            begin
                queue_sequence(p);
            end
            push_rx_byte(2'(p), seq_buf[p][seq_pos[p]]);
            seq_pos[p]++;
        end
        for (p = 0; p < NUM_PORTS; p++)
        begin
            while (seq_pos[p] < seq_len[p])
            begin
                push_rx_byte(2'(p), seq_buf[p][seq_pos[p]]);
                seq_pos[p]++;
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_payload(input logic [6:0] v);
        cfg_valid   <= 1'b1;
        max_payload <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_max = v;
    endtask

    initial
    begin
        logic [6:0] settings [5];
        settings = '{7'd0, 7'd127, 7'd3, 7'($urandom_range(1, 126)), 7'd64};
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            seq_len[i] = 0;
            seq_pos[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_rx_byte(2'd0, 8'h00);
        push_rx_byte(2'd0, 8'hFF);
        push_rx_byte(2'd1, CH_DOLLAR);
        push_rx_byte(2'd1, 8'h4E);
        push_rx_byte(2'd2, CH_DOLLAR);
        push_rx_byte(2'd2, CH_M);
        push_rx_byte(2'd2, 8'h3D);
        push_rx_byte(2'd3, CH_DOLLAR);
        push_rx_byte(2'd3, CH_M);
        push_rx_byte(2'd3, CH_ARROW);
        push_rx_byte(2'd3, 8'h00);
        push_rx_byte(2'd3, 8'hFF);
        push_rx_byte(2'd3, 8'hFF);
        push_rx_byte(2'd0, CH_DOLLAR);
        push_rx_byte(2'd0, CH_M);
        push_rx_byte(2'd0, CH_ARROW);
        push_rx_byte(2'd0, 8'h01);
        push_rx_byte(2'd0, 8'h00);
        push_rx_byte(2'd0, 8'hAA);
        push_rx_byte(2'd0, 8'h55);
        push_rx_byte(2'd1, CH_DOLLAR);
        push_rx_byte(2'd1, CH_M);
        push_rx_byte(2'd1, CH_ARROW);
        push_rx_byte(2'd1, 8'h41);

        for (int k = 0; k < 5; k++)
        begin
            wait_idle();
            write_max_payload(settings[k]);
            if (k == 1)
            begin
                hold_req <= 1'b1;
            end
            quiet <= (k == 3);
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb_serial_command_frame_receiver: PASS");
        end
        else
        begin
            $display("tb_serial_command_frame_receiver: FAIL");
        end
        $finish;
    end

endmodule
